/* rtl/gpc_pkg.sv */
`default_nettype none

package gpc_pkg;

   localparam int NUMBER_WIDTH = 16;
   // trial divisors stay near sqrt(2^NUMBER_WIDTH), plus headroom for the last step
   localparam int DIV_W = NUMBER_WIDTH / 2 + 2;
   localparam int SQ_W = NUMBER_WIDTH + 3;
   localparam int CNT_W = $clog2(NUMBER_WIDTH + 1);
   localparam int COUNT_W = 12;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [NUMBER_WIDTH-1:0] MIN_VALID = NUMBER_WIDTH'(4);
   localparam logic [NUMBER_WIDTH-1:0] SMALLEST_PRIME = NUMBER_WIDTH'(2);
   localparam logic [DIV_W-1:0] FIRST_ODD_DIV = DIV_W'(3);
   localparam logic [SQ_W-1:0] FIRST_ODD_SQ = SQ_W'(9);

   typedef struct packed {
      logic                    start;
      logic [NUMBER_WIDTH-1:0] dividend;
      logic [DIV_W-1:0]        divisor;
   } rem_req_type;

   typedef struct packed {
      logic done;
      logic is_zero;
   } rem_rsp_type;

   typedef struct packed {
      logic                    start;
      logic [NUMBER_WIDTH-1:0] value;
   } prime_req_type;

   typedef struct packed {
      logic done;
      logic prime;
   } prime_rsp_type;

endpackage

`default_nettype wire

/* rtl/goldbach_partition_count.sv */
`default_nettype none

// Goldbach partition counter.
// Input: drive req_even_number and raise start; the beat is taken at a rising
// edge where start is high and busy is low. busy stays high while a number is
// being worked on, and no other beat is taken then.
// Output: one result beat per input, shown for exactly one cycle with rsp_valid
// high: rsp_pair_count (prime pairs p <= q with p + q = n) and rsp_invalid_input.
// Odd numbers and numbers below 4 return invalid with a count of zero in the cycle
// after acceptance, and busy never rises for them.
// Work for a valid n: every candidate p from 2 to n/2 is tested, and q = n - p
// is tested when p is prime. An even or small value is decided without division;
// an odd value is divided by each odd trial divisor from 3 up to its square root,
// all on the one shared bit-serial remainder unit. Each candidate after the first
// passes through a sequencing state before its test.
// The receiver cannot stall: the result beat is gone after its cycle.
// Reset (synchronous, active high) drops any number in flight and returns idle.

module goldbach_partition_count (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   output logic                                busy,
   input  wire  [gpc_pkg::NUMBER_WIDTH-1:0]    req_even_number,
   output logic                                rsp_valid,
   output logic [gpc_pkg::COUNT_W-1:0]         rsp_pair_count,
   output logic                                rsp_invalid_input
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_TESTP = 2'd1;
   localparam logic [1:0] ST_TESTQ = 2'd2;
   localparam logic [1:0] ST_NEXT  = 2'd3;

   logic [1:0]                       state_ff, state_in;
   logic [gpc_pkg::NUMBER_WIDTH-1:0] n_ff, n_in;
   logic [gpc_pkg::NUMBER_WIDTH-1:0] half_ff, half_in;
   logic [gpc_pkg::NUMBER_WIDTH-1:0] p_ff, p_in;
   logic [gpc_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic                             pt_start_ff, pt_start_in;
   logic [gpc_pkg::NUMBER_WIDTH-1:0] pt_value_ff, pt_value_in;
   logic                             valid_ff, valid_in;
   logic [gpc_pkg::COUNT_W-1:0]      out_count_ff, out_count_in;
   logic                             out_invalid_ff, out_invalid_in;
   logic                             accept;
   gpc_pkg::prime_req_type           pt_req;
   gpc_pkg::prime_rsp_type           pt_rsp;

   gpc_prime_test u_prime (
      .clock (clock),
      .reset (reset),
      .req   (pt_req),
      .rsp   (pt_rsp)
   );

   assign pt_req = '{start: pt_start_ff, value: pt_value_ff};
   assign accept = start && (state_ff == ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      n_in           = n_ff;
      half_in        = half_ff;
      p_in           = p_ff;
      count_in       = count_ff;
      pt_start_in    = 1'b0;
      pt_value_in    = pt_value_ff;
      valid_in       = 1'b0;
      out_count_in   = out_count_ff;
      out_invalid_in = out_invalid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_even_number[0] || (req_even_number < gpc_pkg::MIN_VALID)) begin
                  valid_in       = 1'b1;
                  out_count_in   = '0;
                  out_invalid_in = 1'b1;
               end else begin
                  n_in        = req_even_number;
                  half_in     = {1'b0, req_even_number[gpc_pkg::NUMBER_WIDTH-1:1]};
                  p_in        = gpc_pkg::SMALLEST_PRIME;
                  count_in    = '0;
                  pt_start_in = 1'b1;
                  pt_value_in = gpc_pkg::SMALLEST_PRIME;
                  state_in    = ST_TESTP;
               end
            end
         end
         ST_TESTP: begin
            if (pt_rsp.done) begin
               if (pt_rsp.prime) begin
                  pt_start_in = 1'b1;
                  pt_value_in = n_ff - p_ff;
                  state_in    = ST_TESTQ;
               end else begin
                  state_in = ST_NEXT;
               end
            end
         end
         ST_TESTQ: begin
            if (pt_rsp.done) begin
               if (pt_rsp.prime && (count_ff != gpc_pkg::COUNT_MAX)) begin
                  count_in = count_ff + gpc_pkg::COUNT_W'(1);
               end
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (p_ff == half_ff) begin
               valid_in       = 1'b1;
               out_count_in   = count_ff;
               out_invalid_in = 1'b0;
               state_in       = ST_IDLE;
            end else begin
               p_in        = p_ff + gpc_pkg::NUMBER_WIDTH'(1);
               pt_start_in = 1'b1;
               pt_value_in = p_ff + gpc_pkg::NUMBER_WIDTH'(1);
               state_in    = ST_TESTP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pt_start_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pt_start_ff <= pt_start_in;
         valid_ff    <= valid_in;
      end
      n_ff           <= n_in;
      half_ff        <= half_in;
      p_ff           <= p_in;
      count_ff       <= count_in;
      pt_value_ff    <= pt_value_in;
      out_count_ff   <= out_count_in;
      out_invalid_ff <= out_invalid_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = valid_ff;
   assign rsp_pair_count    = out_count_ff;
   assign rsp_invalid_input = out_invalid_ff;

`ifndef NO_ASSERTIONS
   a_invalid_zero_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid_input |-> rsp_pair_count == '0)
      else $error("invalid result carries a nonzero count");

   a_bad_input_fast: assert property (@(posedge clock) disable iff (reset)
      accept && (req_even_number[0] || req_even_number < gpc_pkg::MIN_VALID)
      |=> rsp_valid && rsp_invalid_input && !busy)
      else $error("bad input not answered in one cycle");

   a_good_input_busy: assert property (@(posedge clock) disable iff (reset)
      accept && !req_even_number[0] && req_even_number >= gpc_pkg::MIN_VALID
      |=> busy && !rsp_valid)
      else $error("valid input did not start a search");

   a_candidate_range: assert property (@(posedge clock) disable iff (reset)
      busy |-> p_ff <= half_ff && p_ff >= gpc_pkg::SMALLEST_PRIME)
      else $error("candidate left the range 2..n/2");

   a_single_test: assert property (@(posedge clock) disable iff (reset)
      pt_start_ff |-> !pt_rsp.done)
      else $error("new prime test issued while a result is pending");
`endif

endmodule

`default_nettype wire

/* rtl/gpc_rem_unit.sv */
`default_nettype none

module gpc_rem_unit (
   input  wire                       clock,
   input  wire                       reset,
   input  wire gpc_pkg::rem_req_type req,
   output gpc_pkg::rem_rsp_type      rsp
);

   logic                              active_ff, active_in;
   logic [gpc_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic [gpc_pkg::NUMBER_WIDTH-1:0]  dvd_ff, dvd_in;
   logic [gpc_pkg::DIV_W-1:0]         dvs_ff, dvs_in;
   logic [gpc_pkg::DIV_W-1:0]         rem_ff, rem_in;
   logic                              done_ff, done_in;
   logic                              zero_ff, zero_in;
   logic [gpc_pkg::DIV_W:0]           trial;

   // restoring remainder, one dividend bit per cycle, MSB first
   always_comb begin
      active_in = active_ff;
      cnt_in    = cnt_ff;
      dvd_in    = dvd_ff;
      dvs_in    = dvs_ff;
      rem_in    = rem_ff;
      done_in   = 1'b0;
      zero_in   = zero_ff;
      trial     = {rem_ff, dvd_ff[gpc_pkg::NUMBER_WIDTH-1]};
      if (active_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = gpc_pkg::DIV_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = gpc_pkg::DIV_W'(trial);
         end
         dvd_in = {dvd_ff[gpc_pkg::NUMBER_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - gpc_pkg::CNT_W'(1);
         if (cnt_ff == gpc_pkg::CNT_W'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
            zero_in   = (rem_in == '0);
         end
      end else if (req.start) begin
         active_in = 1'b1;
         cnt_in    = gpc_pkg::CNT_W'(gpc_pkg::NUMBER_WIDTH);
         dvd_in    = req.dividend;
         dvs_in    = req.divisor;
         rem_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
         done_ff   <= done_in;
      end
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
      zero_ff <= zero_in;
   end

   assign rsp = '{done: done_ff, is_zero: zero_ff};

endmodule

`default_nettype wire

/* rtl/gpc_prime_test.sv */
`default_nettype none

module gpc_prime_test (
   input  wire                         clock,
   input  wire                         reset,
   input  wire gpc_pkg::prime_req_type req,
   output gpc_pkg::prime_rsp_type      rsp
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;

   logic [1:0]                       state_ff, state_in;
   logic [gpc_pkg::NUMBER_WIDTH-1:0] value_ff, value_in;
   logic [gpc_pkg::DIV_W-1:0]        div_ff, div_in;
   logic [gpc_pkg::SQ_W-1:0]         sq_ff, sq_in;
   logic                             done_ff, done_in;
   logic                             prime_ff, prime_in;
   gpc_pkg::rem_req_type             rem_req;
   gpc_pkg::rem_rsp_type             rem_rsp;

   gpc_rem_unit u_rem (
      .clock (clock),
      .reset (reset),
      .req   (rem_req),
      .rsp   (rem_rsp)
   );

   always_comb begin
      state_in         = state_ff;
      value_in         = value_ff;
      div_in           = div_ff;
      sq_in            = sq_ff;
      done_in          = 1'b0;
      prime_in         = prime_ff;
      rem_req.start    = 1'b0;
      rem_req.dividend = value_ff;
      rem_req.divisor  = div_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.start) begin
               value_in = req.value;
               div_in   = gpc_pkg::FIRST_ODD_DIV;
               sq_in    = gpc_pkg::FIRST_ODD_SQ;
               if (req.value < gpc_pkg::SMALLEST_PRIME) begin
                  done_in  = 1'b1;
                  prime_in = 1'b0;
               end else if (!req.value[0]) begin
                  // even: prime only when it is two
                  done_in  = 1'b1;
                  prime_in = (req.value == gpc_pkg::SMALLEST_PRIME);
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (sq_ff > gpc_pkg::SQ_W'(value_ff)) begin
               done_in  = 1'b1;
               prime_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               rem_req.start = 1'b1;
               state_in      = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (rem_rsp.done) begin
               if (rem_rsp.is_zero) begin
                  done_in  = 1'b1;
                  prime_in = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  // odd divisors only: (d+2)^2 = d^2 + 4d + 4
                  div_in   = div_ff + gpc_pkg::DIV_W'(2);
                  sq_in    = sq_ff + gpc_pkg::SQ_W'({div_ff, 2'b00})
                             + gpc_pkg::SQ_W'(4);
                  state_in = ST_CHECK;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      value_ff <= value_in;
      div_ff   <= div_in;
      sq_ff    <= sq_in;
      prime_ff <= prime_in;
   end

   assign rsp = '{done: done_ff, prime: prime_ff};

endmodule

`default_nettype wire

/* verif/goldbach_partition_count_tb.sv */
`timescale 1ns / 1ps

module goldbach_partition_count_tb;

   localparam int NW = gpc_pkg::NUMBER_WIDTH;
   localparam int CW = gpc_pkg::COUNT_W;
   localparam longint CYCLE_LIMIT = 60_000_000;
   localparam int DRAIN_CYCLES = 32;
   localparam int RANDOM_ITEMS = 72;

   typedef struct packed {
      logic [NW-1:0] number;
      logic [CW-1:0] pairs;
      logic          invalid;
   } partition_result_type;

   logic          clock;
   logic          reset;
   logic          start;
   logic          busy;
   logic [NW-1:0] req_even_number;
   logic          rsp_valid;
   logic [CW-1:0] rsp_pair_count;
   logic          rsp_invalid_input;

   partition_result_type expected_pairs[$];
   int                   mismatch_count = 0;
   longint               cycle_count = 0;

   goldbach_partition_count dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_even_number   (req_even_number),
      .rsp_valid         (rsp_valid),
      .rsp_pair_count    (rsp_pair_count),
      .rsp_invalid_input (rsp_invalid_input)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic bit is_prime_by_division(int unsigned v);
      int unsigned d;
      if (v < 2)
         return 1'b0;
      for (d = 2; d * d <= v; d++) begin
         if (v % d == 0)
            return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic partition_result_type goldbach_pairs(logic [NW-1:0] n);
      partition_result_type r;
      int unsigned          p;
      int unsigned          total;
      total = 0;
      r.number = n;
      r.invalid = n[0] || (n < gpc_pkg::MIN_VALID);
      if (!r.invalid) begin
         for (p = 2; p <= n / 2; p++) begin
            if (is_prime_by_division(p) && is_prime_by_division(n - p)) begin
               if (total < gpc_pkg::COUNT_MAX)
                  total++;
            end
         end
      end
      r.pairs = CW'(total);
      return r;
   endfunction

   function automatic int unsigned random_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 10);
      return $urandom_range(20, 80);
   endfunction

   task automatic report_mismatch(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Hold start high after acceptance when gap is zero; the next call must follow at once.
   task automatic send_number(logic [NW-1:0] n, int unsigned gap);
      req_even_number <= n;
      start <= 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      expected_pairs.push_back(goldbach_pairs(n));
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic release_start();
      start <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin : check_results
      partition_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_pairs.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing pending: count %0d invalid %0b",
                                      rsp_pair_count, rsp_invalid_input));
         end else begin
            want = expected_pairs.pop_front();
            if (rsp_pair_count !== want.pairs)
               report_mismatch($sformatf("n=%0d pair_count %0d, want %0d",
                                         want.number, rsp_pair_count, want.pairs));
            if (rsp_invalid_input !== want.invalid)
               report_mismatch($sformatf("n=%0d invalid_input %0b, want %0b",
                                         want.number, rsp_invalid_input, want.invalid));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending",
                  cycle_count, expected_pairs.size());
         $display("goldbach_partition_count regression: fail");
         $finish;
      end
   end

   // Odd numbers and numbers below 4, sent back to back.
   task automatic test_rejected_numbers();
      logic [NW-1:0] list[$] = '{0, 1, 2, 3, 5, 16'hFFFF, 16'h8001, 16'h5555, 16'hAAAB};
      foreach (list[i])
         send_number(list[i], 0);
      release_start();
   endtask

   task automatic test_small_numbers();
      logic [NW-1:0] list[$] = '{4, 6, 10, 12, 30, 98, 100, 210};
      foreach (list[i])
         send_number(list[i], (i % 2 == 0) ? 0 : random_gap());
      release_start();
   endtask

   task automatic test_power_of_two_numbers();
      for (int k = 3; k <= 13; k++)
         send_number(NW'(1) << k, random_gap());
      release_start();
   endtask

   // Largest even input: walks every candidate p from 2 to 16'h7FFF.
   task automatic test_largest_number();
      send_number(16'hFFFE, 1);
      release_start();
   endtask

   task automatic test_random_numbers();
      int unsigned   band;
      logic [NW-1:0] n;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         band = $urandom_range(0, 99);
         if (band < 10)
            n = NW'($urandom_range(0, 16'hFFFF)) | NW'(1);
         else if (band < 15)
            n = NW'($urandom_range(0, 3));
         else if (band < 74)
            n = NW'(2 * $urandom_range(2, 255));
         else if (band < 96)
            n = NW'(2 * $urandom_range(256, 1023));
         else
            n = NW'(2 * $urandom_range(1024, 4095));
         // keep some stretches with no idling between beats
         send_number(n, (i >= 40 && i < 55) ? 0 : random_gap());
      end
      release_start();
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_even_number <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_rejected_numbers();
      test_small_numbers();
      test_power_of_two_numbers();
      test_largest_number();
      test_random_numbers();

      while (expected_pairs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("goldbach_partition_count regression: pass");
      else
         $display("goldbach_partition_count regression: fail");
      $finish;
   end

endmodule

/* sim.f */
rtl/gpc_pkg.sv
rtl/gpc_rem_unit.sv
rtl/gpc_prime_test.sv
rtl/goldbach_partition_count.sv
verif/goldbach_partition_count_tb.sv
